// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  // Classified action of one input transfer.
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_START   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_WRITE   = 3'd4,
    ACT_READ    = 3'd5,
    ACT_NOP     = 3'd6
  } act_t;

  // One classified item as it travels from the front end to the engine.
  typedef struct packed {
    act_t       act;
    logic [7:0] wdata;
    logic       sda_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       ack_level;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_level;
  } res_t;

  // Queue between front end and engine.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Phase counts per command.
  localparam logic [5:0] PHASES_SHORT = 6'd4;
  localparam logic [5:0] PHASES_WRITE = 6'd36;
  localparam logic [5:0] PHASES_READ  = 6'd32;

  localparam logic [15:0] QPERIOD_RST = 16'd1;

endpackage

// ===== rtl/i2c_bit_level_master_unit.sv =====
// Channel | Dir | Handshake          | Payload
// in      | in  | in_tvalid/tready   | tuser: action; tdata: write_data, sda_in
// out     | out | out_tvalid/tready  | tdata: scl, sda, busy, done, read_byte, ack
// cfg     | in  | cfg_we             | cfg_wdata: quarter_period
//
// One input transfer is taken every clock cycle while the queue has room; each yields one result.
// The engine applies a whole item in a single state update, so its state loop sets that rate.
// An input transfer passes through the queue, then the result register, before its result appears.
// A two-entry queue and the result register let either side stall independently.
// Reset (rst_n low, synchronous) idles the engine with SCL and SDA released high.
module i2c_bit_level_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] action
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] sda_in, [15:9] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_drive, [2] busy_res,
                                  // [3] done_res, [11:4] read_byte, [12] ack_level,
                                  // [15:13] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic            f_valid;
  i2cm_pkg::item_t f_item;
  logic            q_valid, q_ready;
  i2cm_pkg::item_t q_item;
  i2cm_pkg::res_t  res;

  // Front end: classify the incoming transfer.
  i2cm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .item_valid (f_valid),
    .item       (f_item)
  );

  // Queue between classification and execution.
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (in_tready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back end: bit-level command engine.
  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {3'b000, res.ack_level, res.read_byte, res.done_res,
                      res.busy_res, res.sda_drive, res.scl_level};

endmodule

// ===== rtl/i2cm_front.sv =====
module i2cm_front (
  input  logic                in_tvalid,
  input  logic [2:0]          in_tuser,
  input  logic [15:0]         in_tdata,
  output logic                item_valid,
  output i2cm_pkg::item_t     item
);

  // Decode the action code and unpack the data fields; unused codes become a no-op.
  always_comb begin
    unique case (in_tuser)
      3'd0:    item.act = i2cm_pkg::ACT_TICK;
      3'd1:    item.act = i2cm_pkg::ACT_START;
      3'd2:    item.act = i2cm_pkg::ACT_RESTART;
      3'd3:    item.act = i2cm_pkg::ACT_STOP;
      3'd4:    item.act = i2cm_pkg::ACT_WRITE;
      3'd5:    item.act = i2cm_pkg::ACT_READ;
      default: item.act = i2cm_pkg::ACT_NOP;
    endcase
    item.wdata  = in_tdata[7:0];
    item.sda_in = in_tdata[8];
  end

  assign item_valid = in_tvalid;

endmodule

// ===== rtl/i2cm_queue.sv =====
module i2cm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  i2cm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2cm_pkg::item_t pop_item
);

  i2cm_pkg::item_t                   mem_r [i2cm_pkg::QDEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_push, do_pop;

  assign push_ready = (count_r != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH))
    else $error("queue fill count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");
`endif

endmodule

// ===== rtl/i2cm_engine.sv =====
module i2cm_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic            item_valid,
  output logic            item_ready,
  input  i2cm_pkg::item_t item,
  output logic            res_valid,
  input  logic            res_ready,
  output i2cm_pkg::res_t  res
);

  typedef enum logic [2:0] {
    K_IDLE, K_START, K_RESTART, K_STOP, K_WRITE, K_READ
  } kind_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } pin_t;

  kind_t           kind_r, kind_nxt;
  logic [5:0]      phase_r, phase_nxt;
  logic [15:0]     tick_r, tick_nxt;
  logic [7:0]      shift_r;
  logic            scl_r, sda_r, ack_r;
  logic            ack_nxt;
  logic [7:0]      hold_r, hold_nxt;
  logic            done_nxt;
  logic [15:0]     qperiod_r;
  logic [15:0]     limit;
  logic [15:0]     tick_inc;
  logic [5:0]      phase_inc;
  logic            out_valid_r;
  i2cm_pkg::res_t  out_r;
  pin_t            pin_cur, pin_nxt;
  logic            take;

  // Pin and shift settings for one quarter phase of a command.
  function automatic pin_t apply_phase(kind_t k, logic [5:0] ph, pin_t cur, logic din);
    pin_t       r;
    logic [1:0] q;
    logic [3:0] b;
    r = cur;
    q = ph[1:0];
    b = ph[5:2];
    unique case (k)
      K_START: begin
        if (q == 2'd0) begin
          r.scl = 1'b1;
          r.sda = 1'b1;
        end else if (q == 2'd2) begin
          r.sda = 1'b0;
        end
      end
      K_RESTART: begin
        unique case (q)
          2'd0: r.scl = 1'b0;
          2'd1: r.sda = 1'b1;
          2'd2: r.scl = 1'b1;
          default: r.sda = 1'b0;
        endcase
      end
      K_STOP: begin
        unique case (q)
          2'd0: r.scl = 1'b0;
          2'd1: r.sda = 1'b0;
          2'd2: r.scl = 1'b1;
          default: r.sda = 1'b1;
        endcase
      end
      K_WRITE: begin
        if (!b[3]) begin
          if (q == 2'd0) begin
            r.scl = 1'b0;
          end else if (q == 2'd1) begin
            r.sda   = cur.shift[7];
            r.shift = {cur.shift[6:0], 1'b0};
          end else if (q == 2'd2) begin
            r.scl = 1'b1;
          end
        end else begin
          if (q == 2'd0) begin
            r.scl = 1'b0;
            r.sda = 1'b1;
          end else if (q == 2'd2) begin
            r.scl = 1'b1;
          end
        end
      end
      K_READ: begin
        if (q == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else if (q == 2'd2) begin
          r.scl = 1'b1;
        end else if (q == 2'd3 && !b[3]) begin
          r.shift[~b[2:0]] = cur.shift[~b[2:0]] | din;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Number of quarter phases a command plays out.
  function automatic logic [5:0] phase_total(kind_t k);
    logic [5:0] t;
    unique case (k)
      K_WRITE: t = i2cm_pkg::PHASES_WRITE;
      K_READ:  t = i2cm_pkg::PHASES_READ;
      default: t = i2cm_pkg::PHASES_SHORT;
    endcase
    return t;
  endfunction

  // The engine takes an item whenever the result slot is free or draining.
  assign item_ready = !out_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = out_valid_r;
  assign res        = out_r;

  assign limit     = (qperiod_r == '0) ? 16'd1 : qperiod_r;
  assign tick_inc  = tick_r + 16'd1;
  assign phase_inc = phase_r + 6'd1;
  assign pin_cur   = '{scl: scl_r, sda: sda_r, shift: shift_r};

  // Command issue and tick advance.
  always_comb begin
    kind_nxt  = kind_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    pin_nxt   = pin_cur;
    ack_nxt   = ack_r;
    hold_nxt  = hold_r;
    done_nxt  = 1'b0;
    if (kind_r == K_IDLE) begin
      unique case (item.act)
        i2cm_pkg::ACT_START:   kind_nxt = K_START;
        i2cm_pkg::ACT_RESTART: kind_nxt = K_RESTART;
        i2cm_pkg::ACT_STOP:    kind_nxt = K_STOP;
        i2cm_pkg::ACT_WRITE:   kind_nxt = K_WRITE;
        i2cm_pkg::ACT_READ:    kind_nxt = K_READ;
        default:               kind_nxt = K_IDLE;
      endcase
      if (kind_nxt != K_IDLE) begin
        phase_nxt = '0;
        tick_nxt  = '0;
        pin_nxt.shift = (kind_nxt == K_WRITE) ? item.wdata : 8'd0;
        pin_nxt = apply_phase(kind_nxt, 6'd0, pin_nxt, item.sda_in);
      end
    end else if (item.act == i2cm_pkg::ACT_TICK) begin
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        tick_nxt = '0;
        if (phase_inc >= phase_total(kind_r)) begin
          if (kind_r == K_WRITE) begin
            ack_nxt = item.sda_in;
          end
          if (kind_r == K_READ) begin
            hold_nxt = shift_r;
          end
          kind_nxt  = K_IDLE;
          phase_nxt = '0;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          pin_nxt   = apply_phase(kind_r, phase_inc, pin_cur, item.sda_in);
        end
      end
    end
  end

  // Command state, quarter-period config and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= K_IDLE;
      phase_r     <= '0;
      tick_r      <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b1;
      hold_r      <= '0;
      qperiod_r   <= i2cm_pkg::QPERIOD_RST;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (cfg_we) begin
        qperiod_r <= cfg_wdata;
      end
      if (take) begin
        kind_r      <= kind_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        shift_r     <= pin_nxt.shift;
        scl_r       <= pin_nxt.scl;
        sda_r       <= pin_nxt.sda;
        ack_r       <= ack_nxt;
        hold_r      <= hold_nxt;
        out_valid_r <= 1'b1;
        out_r.scl_level <= pin_nxt.scl;
        out_r.sda_drive <= pin_nxt.sda;
        out_r.busy_res  <= (kind_nxt != K_IDLE);
        out_r.done_res  <= done_nxt;
        out_r.read_byte <= hold_nxt;
        out_r.ack_level <= ack_nxt;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.done_res && out_r.busy_res))
    else $error("completion reported while still busy");
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != K_IDLE) |-> (phase_r < phase_total(kind_r)))
    else $error("phase step past end of command");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == K_IDLE) |-> (phase_r == '0 && tick_r == '0))
    else $error("idle engine holds stale phase or tick count");
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && done_nxt) |-> (kind_r != K_IDLE && item.act == i2cm_pkg::ACT_TICK))
    else $error("completion without a running command");
`endif

endmodule
